// ===== design/ssp_pkg.sv =====
// shared types and constants for the single-source shortest path unit
// used by ssp_ctrl, ssp_datapath and single_source_shortest_path_unit
package ssp_pkg;

  localparam int VTX_W  = 6;
  localparam int NV_W   = 7;
  localparam int WGT_W  = 16;
  localparam int DIST_W = 27;

  localparam logic [DIST_W-1:0] UNREACHED = 27'd100000000;
  localparam logic [NV_W-1:0]   NV_RESET  = 7'd9;

  // controller to datapath
  typedef struct packed {
    logic start;       // last item accepted: reset search state
    logic clr;         // write initial distance for current vertex
    logic scan_init;
    logic scan_rd;
    logic scan_cmp;
    logic visit;
    logic edge_rd;
    logic edge_chk;
    logic edge_rel;
    logic out_init;
    logic out_rd;
    logic out_load;
    logic done;        // results delivered: empty the edge store
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic vtx_end;     // vertex counter at highest vertex in use
    logic edge_end;    // edge counter at last stored edge
    logic found;       // scan found an unvisited reachable vertex
    logic no_edges;
    logic out_taken;
    logic out_last;
  } sts_t;

endpackage

// ===== design/single_source_shortest_path_unit.sv =====
// Single-source shortest path unit. Edges stream in on the s_axis channel, one
// transfer per cycle while the unit is loading. tdata = {weight, edge_to,
// edge_from}, tuser = has_edge, tlast marks the final item of a graph. The
// final transfer starts a search from vertex 0; s_axis_tready stays low until
// all results are out. Results leave on m_axis in vertex order, one per vertex
// in use, tlast on the highest vertex; tuser is the reached flag and an
// unreachable vertex reports distance 100000000.
// After the final item the unit writes the initial distances, then for each
// visited vertex runs a minimum scan over all vertices in use and relaxes
// every stored edge; a final scan that finds no vertex ends the search. After
// a setup step the results are read out one at a time, the next only after the
// last is taken. These steps share the distance memory port.
// A stalled receiver holds the result register; nothing is lost.
// Reset empties the edge store and sets num_vertices to 9. The user writes
// num_vertices on the cfg channel (always ready) only while the unit is idle;
// the unit does not enforce this. 0 counts as 1, above MAX_VERTICES as MAX_VERTICES.
// depends on ssp_pkg, ssp_ctrl, ssp_datapath
module single_source_shortest_path_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ssp_pkg::NV_W-1:0] cfg_data_i,    // num_vertices
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // edge_from[5:0], edge_to[11:6], weight[27:12], zero
  input  logic        s_axis_tuser_i,  // has_edge
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // vertex[5:0], distance[32:6], zero
  output logic        m_axis_tuser_o,  // reached
  output logic        m_axis_tlast_o
);
  import ssp_pkg::*;

  logic [NV_W-1:0] nv_cfg_q;
  logic [NV_W-1:0] nv;
  cmd_t            cmd;
  sts_t            sts;
  logic            load;
  logic [VTX_W-1:0]  out_vertex;
  logic [DIST_W-1:0] out_distance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_cfg_q <= NV_RESET;
    end else if (cfg_valid_i) begin
      nv_cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (nv_cfg_q == '0) nv = NV_W'(1);
    else if (nv_cfg_q > NV_W'(MAX_VERTICES)) nv = NV_W'(MAX_VERTICES);
    else nv = nv_cfg_q;
  end

  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .load_o     (load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .nv_i           (nv),
    .load_i         (load && s_axis_tuser_i),
    .edge_from_i    (s_axis_tdata_i[5:0]),
    .edge_to_i      (s_axis_tdata_i[11:6]),
    .weight_i       (s_axis_tdata_i[27:12]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_vertex_o   (out_vertex),
    .out_distance_o (out_distance),
    .out_reached_o  (m_axis_tuser_o),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, out_distance, out_vertex};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input accepted while a result is pending");

  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> ({1'b0, out_vertex} == nv - 1'b1))
    else $error("last result not on highest vertex");

  a_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (out_distance != UNREACHED)))
    else $error("reached flag disagrees with distance");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("input not ready after final result");
`endif

endmodule

// ===== design/ssp_datapath.sv =====
// edge store, distance memory, visited bits, scan and relax logic, output register
// depends on ssp_pkg
module ssp_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssp_pkg::cmd_t        cmd_i,
  output ssp_pkg::sts_t        sts_o,
  input  logic [ssp_pkg::NV_W-1:0] nv_i,
  input  logic                 load_i,
  input  logic [ssp_pkg::VTX_W-1:0] edge_from_i,
  input  logic [ssp_pkg::VTX_W-1:0] edge_to_i,
  input  logic [ssp_pkg::WGT_W-1:0] weight_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ssp_pkg::VTX_W-1:0]  out_vertex_o,
  output logic [ssp_pkg::DIST_W-1:0] out_distance_o,
  output logic                 out_reached_o,
  output logic                 out_last_o
);
  import ssp_pkg::*;

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = 2 * VTX_W + WGT_W;

  logic [EW-1:0]     edge_mem [MAX_EDGES];
  logic [DIST_W-1:0] dist_mem [MAX_VERTICES];

  logic [ECW-1:0]          edge_cnt_q;
  logic [EAW-1:0]          eidx_q;
  logic [VTX_W-1:0]        vidx_q, best_q, other_q;
  logic [DIST_W-1:0]       bestd_q, cand_q, dist_rd_q;
  logic                    found_q, hit_q;
  logic [MAX_VERTICES-1:0] vis_q;
  logic [EW-1:0]           edge_rd_q;
  logic                    out_valid_q;

  logic [VTX_W-1:0] nv_m1;
  logic             store_ok;
  logic [VTX_W-1:0] ea, eb, oth_c;
  logic [WGT_W-1:0] ew;
  logic             hit_c;

  assign nv_m1    = VTX_W'(nv_i - 1'b1);
  assign store_ok = load_i && (edge_cnt_q != ECW'(MAX_EDGES)) &&
                    ({1'b0, edge_from_i} < nv_i) && ({1'b0, edge_to_i} < nv_i);

  assign ea = edge_rd_q[VTX_W-1:0];
  assign eb = edge_rd_q[2*VTX_W-1:VTX_W];
  assign ew = edge_rd_q[EW-1:2*VTX_W];

  always_comb begin
    hit_c = 1'b0;
    oth_c = eb;
    if (ea == best_q) begin
      oth_c = eb;
      hit_c = ({1'b0, eb} < nv_i);
    end else if (eb == best_q) begin
      oth_c = ea;
      hit_c = ({1'b0, ea} < nv_i);
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (store_ok) begin
      edge_mem[edge_cnt_q[EAW-1:0]] <= {weight_i, edge_to_i, edge_from_i};
    end
    if (cmd_i.edge_rd) begin
      edge_rd_q <= edge_mem[eidx_q];
    end
    if (cmd_i.clr) begin
      dist_mem[vidx_q[AW-1:0]] <= (vidx_q == '0) ? '0 : UNREACHED;
    end else if (cmd_i.edge_rel && hit_q && (cand_q < dist_rd_q)) begin
      dist_mem[other_q[AW-1:0]] <= cand_q;
    end
    if (cmd_i.scan_rd || cmd_i.out_rd) begin
      dist_rd_q <= dist_mem[vidx_q[AW-1:0]];
    end else if (cmd_i.edge_chk) begin
      dist_rd_q <= dist_mem[oth_c[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      bestd_q <= UNREACHED;
    end else if (cmd_i.scan_cmp && !vis_q[vidx_q[AW-1:0]] && (dist_rd_q < bestd_q)) begin
      bestd_q <= dist_rd_q;
      best_q  <= vidx_q;
    end
    if (cmd_i.edge_chk) begin
      other_q <= oth_c;
      cand_q  <= bestd_q + DIST_W'(ew);
    end
    if (cmd_i.out_load) begin
      out_vertex_o   <= vidx_q;
      out_distance_o <= dist_rd_q;
      out_reached_o  <= (dist_rd_q != UNREACHED);
      out_last_o     <= (vidx_q == nv_m1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q  <= '0;
      eidx_q      <= '0;
      vidx_q      <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      vis_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.done) begin
        edge_cnt_q <= '0;
      end else if (store_ok) begin
        edge_cnt_q <= edge_cnt_q + 1'b1;
      end
      if (cmd_i.start) begin
        vidx_q <= '0;
        vis_q  <= '0;
      end else if (cmd_i.scan_init || cmd_i.out_init) begin
        vidx_q <= '0;
      end else if (cmd_i.clr || cmd_i.scan_cmp) begin
        vidx_q <= vidx_q + 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        vidx_q <= vidx_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_cmp && !vis_q[vidx_q[AW-1:0]] && (dist_rd_q < bestd_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.visit) begin
        eidx_q <= '0;
        if (found_q) begin
          vis_q[best_q[AW-1:0]] <= 1'b1;
        end
      end else if (cmd_i.edge_rel) begin
        eidx_q <= eidx_q + 1'b1;
      end
      if (cmd_i.edge_chk) begin
        hit_q <= hit_c;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.vtx_end    = (vidx_q == nv_m1);
  assign sts_o.edge_end   = (ECW'(eidx_q) == ECW'(edge_cnt_q - 1'b1));
  assign sts_o.found      = found_q;
  assign sts_o.no_edges   = (edge_cnt_q == '0);
  assign sts_o.out_taken  = out_valid_q && out_ready_i;
  assign sts_o.out_last   = out_last_o;

endmodule

// ===== design/ssp_ctrl.sv =====
// sequencer for load, initialization, minimum scan, edge relaxation and output
// depends on ssp_pkg
module ssp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          load_o,
  input  ssp_pkg::sts_t sts_i,
  output ssp_pkg::cmd_t cmd_o
);
  import ssp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN_INIT, S_SCAN_RD, S_SCAN_CMP, S_VISIT,
    S_E_RD, S_E_CHK, S_E_REL, S_O_INIT, S_O_RD, S_O_LOAD, S_O_WAIT
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_o     = accept;

  always_comb begin
    cmd_o           = '0;
    cmd_o.start     = accept && in_last_i;
    cmd_o.clr       = (state_q == S_INIT);
    cmd_o.scan_init = (state_q == S_SCAN_INIT);
    cmd_o.scan_rd   = (state_q == S_SCAN_RD);
    cmd_o.scan_cmp  = (state_q == S_SCAN_CMP);
    cmd_o.visit     = (state_q == S_VISIT);
    cmd_o.edge_rd   = (state_q == S_E_RD);
    cmd_o.edge_chk  = (state_q == S_E_CHK);
    cmd_o.edge_rel  = (state_q == S_E_REL);
    cmd_o.out_init  = (state_q == S_O_INIT);
    cmd_o.out_rd    = (state_q == S_O_RD);
    cmd_o.out_load  = (state_q == S_O_LOAD);
    cmd_o.done      = (state_q == S_O_WAIT) && sts_i.out_taken && sts_i.out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && in_last_i) state_q <= S_INIT;
        end
        S_INIT: begin
          if (sts_i.vtx_end) state_q <= S_SCAN_INIT;
        end
        S_SCAN_INIT: state_q <= S_SCAN_RD;
        S_SCAN_RD:   state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          state_q <= sts_i.vtx_end ? S_VISIT : S_SCAN_RD;
        end
        S_VISIT: begin
          if (!sts_i.found) state_q <= S_O_INIT;
          else if (sts_i.no_edges) state_q <= S_SCAN_INIT;
          else state_q <= S_E_RD;
        end
        S_E_RD:  state_q <= S_E_CHK;
        S_E_CHK: state_q <= S_E_REL;
        S_E_REL: begin
          state_q <= sts_i.edge_end ? S_SCAN_INIT : S_E_RD;
        end
        S_O_INIT: state_q <= S_O_RD;
        S_O_RD:   state_q <= S_O_LOAD;
        S_O_LOAD: state_q <= S_O_WAIT;
        S_O_WAIT: begin
          if (sts_i.out_taken) state_q <= sts_i.out_last ? S_IDLE : S_O_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
